@@ rtl/ebrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ebrt_pkg
// Shared constants and types of the bidirectional extent remap table.
// ----------------------------------------------------------------------------
package ebrt_pkg;

   localparam int MAX_EXTENTS_DEF = 64;
   localparam int BLOCK_BITS_DEF  = 32;
   localparam int FIELD_BITS      = 32;

   typedef enum logic [1:0] {
      ACT_FORWARD = 2'd0,
      ACT_REVERSE = 2'd1,
      ACT_SET     = 2'd2,
      ACT_ADD     = 2'd3
   } action_type;

endpackage

@@ rtl/ebrt_ram.sv @@
// ----------------------------------------------------------------------------
// ebrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ebrt_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/bidirectional_extent_remap_table.sv @@
// ----------------------------------------------------------------------------
// bidirectional_extent_remap_table
// Extent table mapping source block runs onto destination block runs.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the result strobe rsp_valid, which lasts one cycle and cannot be held off.
// Every table search walks the entries one at a time through a single RAM
// read port and one shared cover compare, and free entries skip the compare.
// A lookup costs one walk; a set costs up to four walks plus its table
// writes, and a failed set replays its undo log of at most four writes. An
// identity add writes one free slot without a table search.
// Valid bits live in flip-flops and clear at reset; entry contents need no
// clearing pass.
// ----------------------------------------------------------------------------
module bidirectional_extent_remap_table
   import ebrt_pkg::*;
#(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [FIELD_BITS-1:0] req_key_block,
   input  logic [FIELD_BITS-1:0] req_value_block,
   output logic                  rsp_valid,
   output logic [FIELD_BITS-1:0] rsp_result_block,
   output logic                  rsp_hit,
   output logic                  rsp_status
);

   localparam int BB = BLOCK_BITS;
   localparam int N  = MAX_EXTENTS;
   localparam int IW = $clog2(N);
   localparam int WW = (BB > FIELD_BITS) ? BB : FIELD_BITS;
   localparam logic [BB-1:0] ONE   = BB'(1);
   localparam logic [BB-1:0] TOP   = {BB{1'b1}};
   localparam logic [IW-1:0] LAST  = IW'(N - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_CMP, ST_DECIDE, ST_CUT_A, ST_CUT_B, ST_NEXT,
      ST_ADD, ST_RESTORE
   } state_type;

   typedef enum logic [2:0] {
      PH_FWD, PH_REV, PH_S1, PH_S2, PH_S3, PH_S4
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [BB-1:0]      src_ff, dst_ff, skey_ff, k_ff;
   logic               sel_dst_ff;
   logic [IW-1:0]      cnt_ff, fidx_ff;
   logic               found_ff;
   logic [BB-1:0]      e_src_ff, e_dst_ff, e_span_ff;
   logic [BB-1:0]      res_ff;
   logic               hit_ff, status_ff, rsp_valid_ff;
   logic [N-1:0]       valid_ff;
   logic [IW-1:0]      log_idx_ff   [4];
   logic [3*BB-1:0]    log_word_ff  [4];
   logic               log_valid_ff [4];
   logic [2:0]         log_cnt_ff;

   // RAM port and shared write path
   logic [3*BB-1:0]    rd_data;
   logic               wr_en, vwr_en, vwr_val, log_en, log_valid;
   logic [IW-1:0]      wr_idx;
   logic [3*BB-1:0]    wr_word;

   logic [BB-1:0]      d_src, d_dst, d_span, d_base, d_off;
   logic               d_cover;
   logic               free_ok;
   logic [IW-1:0]      free_idx;
   logic               merge_head, merge_tail;
   logic [1:0]         log_rd;
   logic [WW-1:0]      key_w, val_w, res_w;
   logic [BB-1:0]      key_in, val_in;

   ebrt_ram #(.WIDTH(3 * BB), .DEPTH(N)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_word),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // Trim or widen the block fields to the table's block width
   assign key_w  = WW'(req_key_block);
   assign val_w  = WW'(req_value_block);
   assign key_in = key_w[BB-1:0];
   assign val_in = val_w[BB-1:0];
   assign res_w  = WW'(res_ff);

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = res_w[FIELD_BITS-1:0];
   assign rsp_hit          = hit_ff;
   assign rsp_status       = status_ff;

   // Shared cover compare on the entry just read
   assign d_src   = rd_data[3*BB-1:2*BB];
   assign d_dst   = rd_data[2*BB-1:BB];
   assign d_span  = rd_data[BB-1:0];
   assign d_base  = sel_dst_ff ? d_dst : d_src;
   assign d_off   = skey_ff - d_base;
   assign d_cover = valid_ff[cnt_ff] && (skey_ff >= d_base) && (d_off <= d_span);

   // Lowest free slot
   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign merge_head = found_ff && (e_dst_ff == dst_ff + ONE);
   assign merge_tail = found_ff && (e_dst_ff + e_span_ff == dst_ff - ONE);
   assign log_rd     = 2'(log_cnt_ff - 3'd1);

   // Write path: one table write and one valid update per cycle
   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = fidx_ff;
      wr_word   = {e_src_ff, e_dst_ff, e_span_ff};
      vwr_en    = 1'b0;
      vwr_val   = 1'b0;
      log_en    = 1'b0;
      log_valid = 1'b1;
      unique case (state_ff)
         ST_CUT_A: begin
            if (e_span_ff == '0) begin
               vwr_en = 1'b1;
               log_en = 1'b1;
            end else if (k_ff == '0) begin
               wr_en   = 1'b1;
               wr_word = {e_src_ff + ONE, e_dst_ff + ONE, e_span_ff - ONE};
               log_en  = 1'b1;
            end else if (k_ff == e_span_ff) begin
               wr_en   = 1'b1;
               wr_word = {e_src_ff, e_dst_ff, e_span_ff - ONE};
               log_en  = 1'b1;
            end else if (free_ok) begin
               wr_en     = 1'b1;
               wr_idx    = free_idx;
               wr_word   = {e_src_ff + k_ff + ONE, e_dst_ff + k_ff + ONE,
                            e_span_ff - k_ff - ONE};
               vwr_en    = 1'b1;
               vwr_val   = 1'b1;
               log_en    = 1'b1;
               log_valid = 1'b0;
            end
         end
         ST_CUT_B: begin
            wr_en   = 1'b1;
            wr_word = {e_src_ff, e_dst_ff, k_ff - ONE};
            log_en  = 1'b1;
         end
         ST_DECIDE: begin
            if (phase_ff == PH_S3 && merge_head) begin
               wr_en   = 1'b1;
               wr_word = {e_src_ff - ONE, e_dst_ff - ONE, e_span_ff + ONE};
            end else if (phase_ff == PH_S4) begin
               if (merge_tail) begin
                  wr_en   = 1'b1;
                  wr_word = {e_src_ff, e_dst_ff, e_span_ff + ONE};
               end else if (free_ok) begin
                  wr_en   = 1'b1;
                  wr_idx  = free_idx;
                  wr_word = {src_ff, dst_ff, {BB{1'b0}}};
                  vwr_en  = 1'b1;
                  vwr_val = 1'b1;
               end
            end
         end
         ST_ADD: begin
            if (free_ok) begin
               wr_en   = 1'b1;
               wr_idx  = free_idx;
               wr_word = {src_ff, src_ff, dst_ff};
               vwr_en  = 1'b1;
               vwr_val = 1'b1;
            end
         end
         ST_RESTORE: begin
            if (log_cnt_ff != '0) begin
               wr_en   = 1'b1;
               wr_idx  = log_idx_ff[log_rd];
               wr_word = log_word_ff[log_rd];
               vwr_en  = 1'b1;
               vwr_val = log_valid_ff[log_rd];
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FWD;
         valid_ff     <= '0;
         log_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         status_ff    <= 1'b0;
         res_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (vwr_en) begin
            valid_ff[wr_idx] <= vwr_val;
         end
         if (log_en) begin
            log_idx_ff[log_cnt_ff[1:0]]   <= wr_idx;
            log_word_ff[log_cnt_ff[1:0]]  <= {e_src_ff, e_dst_ff, e_span_ff};
            log_valid_ff[log_cnt_ff[1:0]] <= log_valid;
            log_cnt_ff                    <= log_cnt_ff + 3'd1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  src_ff     <= key_in;
                  dst_ff     <= val_in;
                  skey_ff    <= key_in;
                  cnt_ff     <= '0;
                  log_cnt_ff <= '0;
                  res_ff     <= '0;
                  hit_ff     <= 1'b0;
                  status_ff  <= 1'b0;
                  unique case (action_type'(req_action))
                     ACT_FORWARD: begin
                        sel_dst_ff <= 1'b0;
                        phase_ff   <= PH_FWD;
                        state_ff   <= ST_RD;
                     end
                     ACT_REVERSE: begin
                        sel_dst_ff <= 1'b1;
                        phase_ff   <= PH_REV;
                        state_ff   <= ST_RD;
                     end
                     ACT_SET: begin
                        sel_dst_ff <= 1'b0;
                        phase_ff   <= PH_S1;
                        if (key_in == '0) begin
                           // Source zero: drop the item
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_RD;
                        end
                     end
                     ACT_ADD: state_ff <= ST_ADD;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_RD: begin
               // Skip free entries without waiting for the RAM read
               if (valid_ff[cnt_ff]) begin
                  state_ff <= ST_CMP;
               end else if (cnt_ff == LAST) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_DECIDE;
               end else begin
                  cnt_ff <= cnt_ff + IW'(1);
               end
            end
            ST_CMP: begin
               if (d_cover) begin
                  found_ff  <= 1'b1;
                  fidx_ff   <= cnt_ff;
                  e_src_ff  <= d_src;
                  e_dst_ff  <= d_dst;
                  e_span_ff <= d_span;
                  state_ff  <= ST_DECIDE;
               end else if (cnt_ff == LAST) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_DECIDE;
               end else begin
                  cnt_ff   <= cnt_ff + IW'(1);
                  state_ff <= ST_RD;
               end
            end
            ST_DECIDE: begin
               unique case (phase_ff)
                  PH_FWD: begin
                     hit_ff       <= found_ff;
                     res_ff       <= found_ff ? (skey_ff - e_src_ff + e_dst_ff) : '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  PH_REV: begin
                     hit_ff       <= found_ff;
                     res_ff       <= found_ff ? (skey_ff - e_dst_ff + e_src_ff) : '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  PH_S1: begin
                     if (found_ff && (src_ff - e_src_ff + e_dst_ff == dst_ff)) begin
                        // Mapping unchanged
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else if (found_ff) begin
                        k_ff     <= src_ff - e_src_ff;
                        state_ff <= ST_CUT_A;
                     end else begin
                        state_ff <= ST_NEXT;
                     end
                  end
                  PH_S2: begin
                     if (found_ff) begin
                        k_ff     <= dst_ff - e_dst_ff;
                        state_ff <= ST_CUT_A;
                     end else begin
                        state_ff <= ST_NEXT;
                     end
                  end
                  PH_S3: begin
                     if (merge_head) begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        skey_ff  <= src_ff - ONE;
                        cnt_ff   <= '0;
                        phase_ff <= PH_S4;
                        state_ff <= ST_RD;
                     end
                  end
                  PH_S4: begin
                     if (merge_tail || free_ok) begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        state_ff <= ST_RESTORE;
                     end
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_CUT_A: begin
               if (e_span_ff == '0 || k_ff == '0 || k_ff == e_span_ff) begin
                  state_ff <= ST_NEXT;
               end else if (free_ok) begin
                  state_ff <= ST_CUT_B;
               end else begin
                  state_ff <= ST_RESTORE;
               end
            end
            ST_CUT_B: state_ff <= ST_NEXT;
            ST_NEXT: begin
               // Advance to the next search of the set sequence
               cnt_ff <= '0;
               if (phase_ff == PH_S1) begin
                  if (dst_ff == '0) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     skey_ff    <= dst_ff;
                     sel_dst_ff <= 1'b1;
                     phase_ff   <= PH_S2;
                     state_ff   <= ST_RD;
                  end
               end else begin
                  sel_dst_ff <= 1'b0;
                  state_ff   <= ST_RD;
                  if (src_ff != TOP && dst_ff != TOP) begin
                     skey_ff  <= src_ff + ONE;
                     phase_ff <= PH_S3;
                  end else begin
                     skey_ff  <= src_ff - ONE;
                     phase_ff <= PH_S4;
                  end
               end
            end
            ST_ADD: begin
               status_ff    <= !free_ok;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_RESTORE: begin
               // Replay the undo log newest first, then report full
               if (log_cnt_ff != '0) begin
                  log_cnt_ff <= log_cnt_ff - 3'd1;
               end else begin
                  status_ff    <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
